// File: hdl/cfnt_pkg.sv
package cfnt_pkg;

    localparam int MAX_FACE_SIZE = 1024;
    localparam int SIZE_W        = 11;
    localparam int COORD_W       = 10;
    localparam int COMP_W        = 12;   // signed vector component
    localparam int MAG_W         = 11;
    localparam int SQR_W         = 22;
    localparam int SQ_W          = 24;   // |v|^2
    localparam int REM_W         = 38;   // 127^2 * c^2 remainder
    localparam int PRD_W         = 31;   // q * |v|^2
    localparam int Q_W           = 7;
    localparam int NUM_CELLS     = 7;
    localparam int SCALE_SQ      = 16129;
    localparam logic [7:0] MID   = 8'd128;

    localparam logic [2:0] FACE_PX = 3'd0;
    localparam logic [2:0] FACE_NX = 3'd1;
    localparam logic [2:0] FACE_PY = 3'd2;
    localparam logic [2:0] FACE_NY = 3'd3;
    localparam logic [2:0] FACE_PZ = 3'd4;
    localparam logic [2:0] FACE_NZ = 3'd5;

    typedef struct packed {
        logic [2:0]         face;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
    } t_texel_req;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_texel_rgb;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [PRD_W-1:0] prd;
        logic [Q_W-1:0]   q;
        logic             neg;
    } t_lane;

    typedef struct packed {
        logic            valid;
        logic            nodir;
        logic [SQ_W-1:0] sq;
        t_lane [2:0]     lane;
    } t_stage;

endpackage

// File: hdl/cube_face_normal_texel_top.sv
// Normalisation cube map texel source. Each request (face, column, row) returns the RGB
// texel 128 + trunc(127 * n) for the unit direction n through the texel centre. The block
// takes one request every cycle while the output is not stalled: the front forms the
// integer direction, its squared length and the per-channel targets, then a row of seven
// cells resolves one quotient bit per cell (bit 6 down to bit 0) for all three channels,
// and a last register holds the beat. A stall on a held output beat halts the whole row
// and stalls the input. Faces six and seven give 128 on every channel. face_size (reset 64)
// is clamped to 1..1024 on write and should be changed only while the block is empty.
module cube_face_normal_texel_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [cfnt_pkg::SIZE_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  cfnt_pkg::t_texel_req        i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output cfnt_pkg::t_texel_rgb        o_out_data
);

    logic [cfnt_pkg::SIZE_W-1:0] r_face_size;
    logic                        s_en;
    cfnt_pkg::t_stage            s_chain [cfnt_pkg::NUM_CELLS+1];
    logic                        r_out_valid;
    cfnt_pkg::t_texel_rgb        r_out_data;
    logic [7:0]                  s_ch [3];

    // clamp and hold face size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_size <= cfnt_pkg::SIZE_W'(64);
        end else if (i_cfg_we) begin
            if (i_cfg_data == '0) begin
                r_face_size <= cfnt_pkg::SIZE_W'(1);
            end else if (i_cfg_data > cfnt_pkg::SIZE_W'(cfnt_pkg::MAX_FACE_SIZE)) begin
                r_face_size <= cfnt_pkg::SIZE_W'(cfnt_pkg::MAX_FACE_SIZE);
            end else begin
                r_face_size <= i_cfg_data;
            end
        end
    end

    // advance the whole row unless a held beat is stalled
    assign s_en       = !r_out_valid || !i_out_stall;
    assign o_in_stall = !s_en;

    cfnt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (s_en),
        .i_valid     (i_in_valid),
        .i_req       (i_in_data),
        .i_face_size (r_face_size),
        .o_d         (s_chain[0])
    );

    for (genvar g = 0; g < cfnt_pkg::NUM_CELLS; g++) begin : g_cell
        cfnt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (s_en),
            .i_k     (3'(cfnt_pkg::NUM_CELLS - 1 - g)),
            .i_d     (s_chain[g]),
            .o_d     (s_chain[g+1])
        );
    end

    // apply sign around mid-scale
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (s_chain[cfnt_pkg::NUM_CELLS].nodir) begin
                s_ch[i] = cfnt_pkg::MID;
            end else if (s_chain[cfnt_pkg::NUM_CELLS].lane[i].neg) begin
                s_ch[i] = cfnt_pkg::MID - 8'(s_chain[cfnt_pkg::NUM_CELLS].lane[i].q);
            end else begin
                s_ch[i] = cfnt_pkg::MID + 8'(s_chain[cfnt_pkg::NUM_CELLS].lane[i].q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_en) begin
            r_out_valid <= s_chain[cfnt_pkg::NUM_CELLS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_out_data.red   <= s_ch[0];
            r_out_data.green <= s_ch[1];
            r_out_data.blue  <= s_ch[2];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: hdl/cfnt_front.sv
module cfnt_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  cfnt_pkg::t_texel_req        i_req,
    input  logic [cfnt_pkg::SIZE_W-1:0] i_face_size,
    output cfnt_pkg::t_stage            o_d
);

    logic signed [cfnt_pkg::COMP_W-1:0] s_u, s_a, s_b;
    logic signed [cfnt_pkg::COMP_W-1:0] s_v [3];
    logic                               s_nodir;

    logic                          r_v1, r_v2, r_v3;
    logic                          r_nd1, r_nd2, r_nd3;
    logic [2:0]                    r_neg1, r_neg2, r_neg3;
    logic [cfnt_pkg::MAG_W-1:0]    r_mag [3];
    logic [cfnt_pkg::SQR_W-1:0]    r_sqr [3];
    logic [cfnt_pkg::SQ_W-1:0]     r_sq;
    logic [cfnt_pkg::REM_W-1:0]    r_tgt [3];

    // form the scaled centre direction for the requested face
    always_comb begin
        s_u = cfnt_pkg::COMP_W'(i_face_size);
        s_a = (cfnt_pkg::COMP_W'(i_req.column) <<< 1) + 12'sd1 - s_u;
        s_b = (cfnt_pkg::COMP_W'(i_req.row) <<< 1) + 12'sd1 - s_u;
        s_nodir = 1'b0;
        case (i_req.face)
            cfnt_pkg::FACE_PX: begin s_v[0] = s_u;  s_v[1] = -s_b; s_v[2] = -s_a; end
            cfnt_pkg::FACE_NX: begin s_v[0] = -s_u; s_v[1] = -s_b; s_v[2] = s_a;  end
            cfnt_pkg::FACE_PY: begin s_v[0] = s_a;  s_v[1] = s_u;  s_v[2] = s_b;  end
            cfnt_pkg::FACE_NY: begin s_v[0] = s_a;  s_v[1] = -s_u; s_v[2] = -s_b; end
            cfnt_pkg::FACE_PZ: begin s_v[0] = s_a;  s_v[1] = -s_b; s_v[2] = s_u;  end
            cfnt_pkg::FACE_NZ: begin s_v[0] = -s_a; s_v[1] = -s_b; s_v[2] = -s_u; end
            default: begin
                s_v[0] = '0; s_v[1] = '0; s_v[2] = '0;
                s_nodir = 1'b1;
            end
        endcase
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // magnitude, square, then sum and scaled target
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nd1 <= s_nodir;
            r_nd2 <= r_nd1;
            r_nd3 <= r_nd2;
            r_neg2 <= r_neg1;
            r_neg3 <= r_neg2;
            for (int i = 0; i < 3; i++) begin
                r_neg1[i] <= s_v[i][cfnt_pkg::COMP_W-1];
                r_mag[i]  <= s_v[i][cfnt_pkg::COMP_W-1]
                           ? cfnt_pkg::MAG_W'(-s_v[i]) : cfnt_pkg::MAG_W'(s_v[i]);
                r_sqr[i]  <= cfnt_pkg::SQR_W'(r_mag[i]) * cfnt_pkg::SQR_W'(r_mag[i]);
                r_tgt[i]  <= cfnt_pkg::REM_W'(r_sqr[i]) * cfnt_pkg::REM_W'(cfnt_pkg::SCALE_SQ);
            end
            r_sq <= cfnt_pkg::SQ_W'(r_sqr[0]) + cfnt_pkg::SQ_W'(r_sqr[1])
                  + cfnt_pkg::SQ_W'(r_sqr[2]);
        end
    end

    always_comb begin
        o_d.valid = r_v3;
        o_d.nodir = r_nd3;
        o_d.sq    = r_sq;
        for (int i = 0; i < 3; i++) begin
            o_d.lane[i].rem = r_tgt[i];
            o_d.lane[i].prd = '0;
            o_d.lane[i].q   = '0;
            o_d.lane[i].neg = r_neg3[i];
        end
    end

endmodule

// File: hdl/cfnt_cell.sv
module cfnt_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [2:0]       i_k,
    input  cfnt_pkg::t_stage i_d,
    output cfnt_pkg::t_stage o_d
);

    cfnt_pkg::t_stage                n_d;
    cfnt_pkg::t_stage                r_d;
    logic [cfnt_pkg::REM_W:0]        s_trial;
    logic [cfnt_pkg::REM_W:0]        s_rem;
    logic [3:0]                      s_sh1, s_sh2;

    // try one quotient bit on each channel: (2q + 2^k) * 2^k * sq against remainder
    always_comb begin
        n_d   = i_d;
        s_sh1 = {1'b0, i_k} + 4'd1;
        s_sh2 = {i_k, 1'b0};
        s_trial = '0;
        s_rem   = '0;
        for (int i = 0; i < 3; i++) begin
            s_trial = ((cfnt_pkg::REM_W+1)'(i_d.lane[i].prd) << s_sh1)
                    + ((cfnt_pkg::REM_W+1)'(i_d.sq) << s_sh2);
            s_rem   = (cfnt_pkg::REM_W+1)'(i_d.lane[i].rem);
            if (s_rem >= s_trial) begin
                n_d.lane[i].rem = cfnt_pkg::REM_W'(s_rem - s_trial);
                n_d.lane[i].prd = i_d.lane[i].prd
                                + (cfnt_pkg::PRD_W'(i_d.sq) << i_k);
                n_d.lane[i].q   = i_d.lane[i].q | (cfnt_pkg::Q_W'(1) << i_k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end else if (i_en) begin
            r_d.valid <= n_d.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d.nodir <= n_d.nodir;
            r_d.sq    <= n_d.sq;
            r_d.lane  <= n_d.lane;
        end
    end

    assign o_d = r_d;

endmodule

// File: hdl/cfnt_checker.sv
module cfnt_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input cfnt_pkg::t_texel_rgb o_out_data
);

    // hold a stalled beat
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output beat changed");

    // input stalls only behind a stalled output beat
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back-pressure");

    // channels never reach zero
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.red != 8'd0 && o_out_data.green != 8'd0
                        && o_out_data.blue != 8'd0)
        else $error("channel out of range");

endmodule

bind cube_face_normal_texel_top cfnt_checker u_cfnt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// File: verif/cube_face_normal_texel_top_test.sv
module cube_face_normal_texel_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Compares returned texels with predicted texels, oldest first
    class texel_board;
        cfnt_pkg::t_texel_rgb pending[$];
        int                   errors;

        function void note_request(cfnt_pkg::t_texel_rgb rgb);
            pending.push_back(rgb);
        endfunction

        task automatic check_texel(cfnt_pkg::t_texel_rgb got);
            cfnt_pkg::t_texel_rgb want;
            if (pending.size() == 0) begin
                report_err("texel beat with no request waiting");
            end else begin
                want = pending.pop_front();
                if (got.red !== want.red)
                    report_err($sformatf("red got %0d want %0d", got.red, want.red));
                if (got.green !== want.green)
                    report_err($sformatf("green got %0d want %0d", got.green, want.green));
                if (got.blue !== want.blue)
                    report_err($sformatf("blue got %0d want %0d", got.blue, want.blue));
            end
        endtask

        task automatic report_err(string msg);
            errors++;
            $display("%0t mismatch: %s", $realtime, msg);
        endtask
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [cfnt_pkg::SIZE_W-1:0] i_cfg_data = '0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    cfnt_pkg::t_texel_req i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    cfnt_pkg::t_texel_rgb o_out_data;

    texel_board board = new();
    int unsigned cur_size = 64;
    int  sink_idle_pct = 19;
    int  hold_cycles = 0;
    bit  hold_now = 1'b0;

    always #4 i_clk = ~i_clk;

    cube_face_normal_texel_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );

    // Largest q with q*q*sq <= 16129*c*c, signed about 128
    function automatic logic [7:0] channel_value(longint c, longint sq);
        longint mag, target, q, t;
        mag = c < 0 ? -c : c;
        target = 16129 * mag * mag;
        q = 0;
        for (int b = 7; b >= 0; b--) begin
            t = q | (64'd1 << b);
            if (t * t * sq <= target) q = t;
        end
        return c < 0 ? 8'(128 - q) : 8'(128 + q);
    endfunction

    function automatic cfnt_pkg::t_texel_rgb texel_of(cfnt_pkg::t_texel_req req);
        longint u, a, b, vx, vy, vz, sq;
        cfnt_pkg::t_texel_rgb rgb;
        u = cur_size;
        a = 2 * longint'(req.column) + 1 - u;
        b = 2 * longint'(req.row) + 1 - u;
        case (req.face)
            cfnt_pkg::FACE_PX: begin vx = u;  vy = -b; vz = -a; end
            cfnt_pkg::FACE_NX: begin vx = -u; vy = -b; vz = a;  end
            cfnt_pkg::FACE_PY: begin vx = a;  vy = u;  vz = b;  end
            cfnt_pkg::FACE_NY: begin vx = a;  vy = -u; vz = -b; end
            cfnt_pkg::FACE_PZ: begin vx = a;  vy = -b; vz = u;  end
            cfnt_pkg::FACE_NZ: begin vx = -a; vy = -b; vz = -u; end
            default: begin
                rgb.red = cfnt_pkg::MID; rgb.green = cfnt_pkg::MID; rgb.blue = cfnt_pkg::MID;
                return rgb;
            end
        endcase
        sq = vx * vx + vy * vy + vz * vz;
        rgb.red = channel_value(vx, sq);
        rgb.green = channel_value(vy, sq);
        rgb.blue = channel_value(vz, sq);
        return rgb;
    endfunction

    // Offer one beat and hold it until accepted
    task automatic send_texel(cfnt_pkg::t_texel_req req, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_request(texel_of(req));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Write face_size while empty; clamp as the block does
    task automatic set_size(int unsigned val);
        i_cfg_we <= 1'b1;
        i_cfg_data <= cfnt_pkg::SIZE_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_size = val == 0 ? 1
                 : (val > cfnt_pkg::MAX_FACE_SIZE ? cfnt_pkg::MAX_FACE_SIZE : val);
        @(posedge i_clk);
    endtask

    function automatic cfnt_pkg::t_texel_req rand_req();
        cfnt_pkg::t_texel_req r;
        int unsigned lim;
        lim = cur_size > 1024 ? 1023 : cur_size - 1;
        r.face = ($urandom_range(15) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
        if ($urandom_range(9) == 0) begin
            r.column = 10'($urandom);
            r.row = 10'($urandom);
        end else begin
            r.column = 10'($urandom_range(lim));
            r.row = 10'($urandom_range(lim));
        end
        return r;
    endfunction

    // Sink: random stall, with a long hold on request
    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall && i_rst_n) board.check_texel(o_out_data);
        if (hold_now) begin
            hold_now <= 1'b0;
            hold_cycles <= 300;
            i_out_stall <= 1'b1;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= $urandom_range(99) < sink_idle_pct;
        end
    end

    initial begin
        cfnt_pkg::t_texel_req r;
        int unsigned sizes[6];
        sizes = '{1, 1024, 0, 2047, 3, 64};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset size, corners, every face, odd faces and out of range
        for (int f = 0; f < 8; f++) begin
            r.face = 3'(f); r.column = '0; r.row = 10'd63;
            send_texel(r, 0);
        end
        r.face = cfnt_pkg::FACE_PX; r.column = 10'h3FF; r.row = 10'h3FF; send_texel(r, 0);
        r.face = cfnt_pkg::FACE_NZ; r.column = 10'd63; r.row = 10'd0; send_texel(r, 0);
        r.face = cfnt_pkg::FACE_PY; r.column = 10'd32; r.row = 10'd31; send_texel(r, 0);
        drain();
        set_size(1024);
        r.face = cfnt_pkg::FACE_PZ; r.column = 10'h3FF; r.row = 10'h3FF; send_texel(r, 0);
        r.face = cfnt_pkg::FACE_NY; r.column = 10'd0; r.row = 10'h3FF; send_texel(r, 0);
        r.face = cfnt_pkg::FACE_NX; r.column = 10'd512; r.row = 10'd511; send_texel(r, 0);
        drain();

        // Random phases across sizes, extremes among them
        foreach (sizes[k]) begin
            set_size(sizes[k]);
            for (int n = 0; n < 220; n++) begin
                if (k == 1 && n == 50) hold_now <= 1'b1;
                if (k == 4 && n == 100) drain();
                send_texel(rand_req(), (k == 5) ? 0 : 19);
            end
            drain();
        end

        if (board.errors == 0)
            $display("cube_face_normal_texel_top verification clean");
        else
            $display("cube_face_normal_texel_top verification failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("cube_face_normal_texel_top verification failed");
        $finish;
    end
endmodule
